### sv/ssc_pkg.sv
package ssc_pkg;

    // Field widths of the command and result items.
    localparam int IDX_W = 8;
    localparam int VAL_W = 32;

    // Value every register takes after reset or a clear item.
    localparam logic [VAL_W-1:0] RESET_PATTERN = 32'hFFFF_FFFE;

    // Number of dirty bits examined per cycle by the group scan.
    localparam int SCAN_W = 8;

    // Action codes; code 3 is unused and ignored.
    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_FLUSH = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] state_index;
        logic [VAL_W-1:0] new_value;
    } cmd_item_t;

    typedef struct packed {
        logic             write_valid;
        logic [IDX_W-1:0] write_index;
        logic [VAL_W-1:0] write_value;
        logic             last_of_step;
        logic             more_dirty;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_CMP,
        ST_SCAN,
        ST_FL_RD,
        ST_FL_CMP,
        ST_FL_END
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clear_start;
        logic clr_wr;
        logic set_rd;
        logic set_wr;
        logic flush_start;
        logic scan_step;
        logic fl_rd;
        logic fl_take;
        logic fl_end;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic act_set;
        logic act_flush;
        logic act_clear;
        logic idx_ok;
        logic any_dirty;
        logic clr_done;
        logic set_differ;
        logic scan_hit;
        logic fl_differ;
        logic pend_valid;
        logic slot_free;
        logic last_entry;
    } dp_status_t;

endpackage

### sv/ssc_ram.sv
module ssc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/ssc_ctrl.sv
module ssc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ssc_pkg::dp_status_t st,
    output ssc_pkg::dp_cmd_t    dc
);

    import ssc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing sweep of both memories.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        dc         = '0;
        cmd_stall  = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                dc.clr_wr = 1'b1;
                if (st.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid)
                begin
                    dc.load_item = 1'b1;
                    if (st.act_set && st.idx_ok)
                    begin
                        state_next = ST_SET_RD;
                    end
                    else if (st.act_flush)
                    begin
                        dc.flush_start = 1'b1;
                        state_next     = st.any_dirty ? ST_SCAN : ST_FL_END;
                    end
                    else if (st.act_clear)
                    begin
                        dc.clear_start = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                end
            end
            ST_SET_RD:
            begin
                dc.set_rd  = 1'b1;
                state_next = ST_SET_CMP;
            end
            ST_SET_CMP:
            begin
                dc.set_wr  = st.set_differ;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                dc.scan_step = 1'b1;
                if (st.scan_hit)
                begin
                    state_next = ST_FL_RD;
                end
            end
            ST_FL_RD:
            begin
                dc.fl_rd   = 1'b1;
                state_next = ST_FL_CMP;
            end
            ST_FL_CMP:
            begin
                // A changed entry behind a pending one needs room in the output.
                if (!(st.fl_differ && st.pend_valid && !st.slot_free))
                begin
                    dc.fl_take = 1'b1;
                    state_next = st.last_entry ? ST_FL_END : ST_FL_RD;
                end
            end
            ST_FL_END:
            begin
                if (st.slot_free)
                begin
                    dc.fl_end  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ssc_dpath.sv
module ssc_dpath #(
    parameter int NUM_REGS   = 256,
    parameter int GROUP_SIZE = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ssc_pkg::cmd_item_t  cmd,
    input  ssc_pkg::dp_cmd_t    dc,
    output ssc_pkg::dp_status_t st,
    output logic                res_valid,
    input  logic                res_stall,
    output ssc_pkg::res_item_t  res
);

    import ssc_pkg::*;

    localparam int NUM_GROUPS = (NUM_REGS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int AW         = $clog2(NUM_REGS);
    localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CNTW       = $clog2(NUM_GROUPS + 1);
    localparam int KW         = $clog2(GROUP_SIZE);
    localparam int NCHUNK     = (NUM_GROUPS + SCAN_W - 1) / SCAN_W;
    localparam int CW         = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PADW       = NCHUNK * SCAN_W;
    localparam int PW         = $clog2(SCAN_W);
    localparam int IDX_SPAN   = 1 << IDX_W;

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_REGS - 1);
    localparam logic [KW-1:0] LAST_K    = KW'(GROUP_SIZE - 1);

    // Captured item.
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [VAL_W-1:0]      val_reg, val_next;

    // Dirty bookkeeping and sequencing.
    logic [NUM_GROUPS-1:0] dirty_reg, dirty_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [CW-1:0]         chunk_reg, chunk_next;
    logic                  more_reg, more_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [KW-1:0]         k_reg, k_next;

    // Pending changed entry, held back until it is known whether it is the last.
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [VAL_W-1:0]      pend_val_reg, pend_val_next;

    // Output register.
    logic                  res_valid_reg, res_valid_next;
    res_item_t             res_reg, res_next;

    logic [AW-1:0]         idx_addr;
    logic [GW-1:0]         set_grp;
    logic [GW-1:0]         group_lut [IDX_SPAN];
    logic [PADW-1:0]       dirty_pad;
    logic [SCAN_W-1:0]     chunk_bits;
    logic [PW-1:0]         hit_pos;
    logic [GW-1:0]         grp_found;
    logic [AW-1:0]         grp_base;
    logic                  scan_hit;
    logic                  fl_differ;
    logic                  slot_free;
    logic                  last_entry;
    logic                  emit_mid;

    logic                  cur_we, cur_re, fl_we;
    logic [AW-1:0]         cur_waddr, cur_raddr, fl_waddr;
    logic [VAL_W-1:0]      cur_wdata, fl_wdata, rd_cur, rd_fl;

    // Group of each possible index, fixed at elaboration.
    for (genvar gi = 0; gi < IDX_SPAN; gi++)
    begin : g_lut
        assign group_lut[gi] = GW'(gi / GROUP_SIZE);
    end

    assign idx_addr = AW'(32'(idx_reg));
    assign set_grp  = group_lut[idx_reg];

    // Lowest dirty group within the chunk under scan.
    assign dirty_pad  = PADW'(dirty_reg);
    assign chunk_bits = dirty_pad[chunk_reg * SCAN_W +: SCAN_W];
    assign scan_hit   = |chunk_bits;

    always_comb
    begin
        hit_pos = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                hit_pos = PW'(i);
            end
        end
    end

    assign grp_found  = GW'(32'(chunk_reg) * SCAN_W + 32'(hit_pos));
    assign grp_base   = AW'(32'(grp_found) * GROUP_SIZE);

    assign fl_differ  = rd_cur != rd_fl;
    assign slot_free  = !res_valid_reg || !res_stall;
    assign last_entry = (k_reg == LAST_K) || (addr_reg == LAST_ADDR);
    assign emit_mid   = dc.fl_take && fl_differ && pend_valid_reg;

    // Status towards the controller.
    always_comb
    begin
        st.act_set    = cmd.action == ACT_SET;
        st.act_flush  = cmd.action == ACT_FLUSH;
        st.act_clear  = cmd.action == ACT_CLEAR;
        st.idx_ok     = 32'(cmd.state_index) < NUM_REGS;
        st.any_dirty  = count_reg != '0;
        st.clr_done   = clr_addr_reg == LAST_ADDR;
        st.set_differ = rd_cur != val_reg;
        st.scan_hit   = scan_hit;
        st.fl_differ  = fl_differ;
        st.pend_valid = pend_valid_reg;
        st.slot_free  = slot_free;
        st.last_entry = last_entry;
    end

    // Memory ports: the clearing sweep writes both, set and flush share the rest.
    always_comb
    begin
        cur_we    = dc.clr_wr || dc.set_wr;
        cur_waddr = dc.clr_wr ? clr_addr_reg : idx_addr;
        cur_wdata = dc.clr_wr ? RESET_PATTERN : val_reg;
        cur_re    = dc.set_rd || dc.fl_rd;
        cur_raddr = dc.set_rd ? idx_addr : addr_reg;
        fl_we     = dc.clr_wr || (dc.fl_take && fl_differ);
        fl_waddr  = dc.clr_wr ? clr_addr_reg : addr_reg;
        fl_wdata  = dc.clr_wr ? RESET_PATTERN : rd_cur;
    end

    ssc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_REGS)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (cur_re),
        .raddr (cur_raddr),
        .rdata (rd_cur)
    );

    ssc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_REGS)
    ) u_fl_ram (
        .clk   (clk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (dc.fl_rd),
        .raddr (addr_reg),
        .rdata (rd_fl)
    );

    // Item capture, dirty bits and group walk.
    always_comb
    begin
        idx_next      = idx_reg;
        val_next      = val_reg;
        dirty_next    = dirty_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        chunk_next    = chunk_reg;
        more_next     = more_reg;
        addr_next     = addr_reg;
        k_next        = k_reg;

        if (dc.load_item)
        begin
            idx_next = cmd.state_index;
            val_next = cmd.new_value;
        end

        if (dc.clear_start)
        begin
            dirty_next    = '0;
            count_next    = '0;
            clr_addr_next = '0;
        end
        else if (dc.set_wr)
        begin
            if (!dirty_reg[set_grp])
            begin
                dirty_next[set_grp] = 1'b1;
                count_next          = count_reg + CNTW'(1);
            end
        end
        else if (dc.scan_step && scan_hit)
        begin
            dirty_next[grp_found] = 1'b0;
            count_next            = count_reg - CNTW'(1);
        end

        if (dc.clr_wr)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (dc.flush_start)
        begin
            chunk_next = '0;
            more_next  = 1'b0;
        end

        if (dc.scan_step)
        begin
            if (scan_hit)
            begin
                more_next = count_reg != CNTW'(1);
                addr_next = grp_base;
                k_next    = '0;
            end
            else
            begin
                chunk_next = chunk_reg + CW'(1);
            end
        end

        if (dc.fl_take && !last_entry)
        begin
            addr_next = addr_reg + AW'(1);
            k_next    = k_reg + KW'(1);
        end
    end

    // Pending entry and output register.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_val_next   = pend_val_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && res_stall;

        if (dc.fl_take && fl_differ)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = IDX_W'(addr_reg);
            pend_val_next   = rd_cur;
        end

        if (emit_mid)
        begin
            res_valid_next        = 1'b1;
            res_next.write_valid  = 1'b1;
            res_next.write_index  = pend_idx_reg;
            res_next.write_value  = pend_val_reg;
            res_next.last_of_step = 1'b0;
            res_next.more_dirty   = more_reg;
        end
        else if (dc.fl_end)
        begin
            pend_valid_next       = 1'b0;
            res_valid_next        = 1'b1;
            res_next.write_valid  = pend_valid_reg;
            res_next.write_index  = pend_valid_reg ? pend_idx_reg : '0;
            res_next.write_value  = pend_valid_reg ? pend_val_reg : '0;
            res_next.last_of_step = 1'b1;
            res_next.more_dirty   = more_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg      <= '0;
            count_reg      <= '0;
            clr_addr_reg   <= '0;
            chunk_reg      <= '0;
            more_reg       <= 1'b0;
            addr_reg       <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            dirty_reg      <= dirty_next;
            count_reg      <= count_next;
            clr_addr_reg   <= clr_addr_next;
            chunk_reg      <= chunk_next;
            more_reg       <= more_next;
            addr_reg       <= addr_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        pend_idx_reg <= pend_idx_next;
        pend_val_reg <= pend_val_next;
        res_reg      <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### sv/shadow_state_cache_lazy_flush.sv
// Channel  Direction  Handshake            Payload
// cmd      in         cmd_valid/cmd_stall  ssc_pkg::cmd_item_t (action, index, value)
// res      out        res_valid/res_stall  ssc_pkg::res_item_t (at most one flushed register)
//
// A set item passes through accept, a read of the current-value RAM, then compare and write.
// A flush step scans the dirty bits in 8-group chunks up to the lowest dirty group, then
// walks that group; each entry needs a read and a compare on the RAMs.
// A clear item, and reset, start a sweep that writes the reset pattern into every entry
// of both RAMs while cmd_stall stays high.
// Results leave through an output register; a stalled result holds the walk when a
// further changed register is found behind it, and holds back the step's closing result.
module shadow_state_cache_lazy_flush #(
    parameter int NUM_REGS   = 256,
    parameter int GROUP_SIZE = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ssc_pkg::cmd_item_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output ssc_pkg::res_item_t res
);

    import ssc_pkg::*;

    dp_cmd_t    dc;
    dp_status_t st;

    // Sequencer.
    ssc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .st        (st),
        .dc        (dc)
    );

    // Register stores, dirty bits and output register.
    ssc_dpath #(
        .NUM_REGS   (NUM_REGS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dc        (dc),
        .st        (st),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

### sv/ssc_checker.sv
module ssc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_stall,
    input ssc_pkg::res_item_t res
);

    // A stalled result stays offered.
    a_res_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_res_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result payload changed while stalled");

    // An empty result closes its step and carries zeros.
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.write_valid |->
            res.last_of_step && res.write_index == '0 && res.write_value == '0)
        else $error("malformed empty result");

    // Only a result carrying a register can be followed by more of the same step.
    a_mid_carries: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last_of_step |-> res.write_valid)
        else $error("non-final result without a register");

endmodule

bind shadow_state_cache_lazy_flush ssc_checker u_chk (.*);

### tb/tb_shadow_state_cache_lazy_flush.sv
`timescale 1ns / 100ps

module tb_shadow_state_cache_lazy_flush;

    import ssc_pkg::*;

    localparam int NUM_REGS    = 256;
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = NUM_REGS / GROUP_SIZE;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 60;

    // One command item waiting to be sent; a marked item is held back until
    // every flushed register expected so far has come out.
    typedef struct {
        cmd_item_t item;
        bit        wait_drain;
    } pending_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    // Commands still to be sent, and flushed registers still to come out.
    pending_cmd_t cmd_backlog[$];
    res_item_t    flush_writes[$];

    // Our own copy of the cache: live values, values last sent downstream and
    // one dirty bit per group.
    logic [VAL_W-1:0]      shadow_regs[NUM_REGS];
    logic [VAL_W-1:0]      sent_regs[NUM_REGS];
    logic [NUM_GROUPS-1:0] dirty_mask;

    int open_results;
    int mismatch_count = 0;
    int cycle_count = 0;
    int gap_left;
    int stall_left;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    shadow_state_cache_lazy_flush dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_shadow_state_cache_lazy_flush: errors");
            $finish;
        end
    end

    // Records a failure; only the first ten are described.
    function automatic void note_failure(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, what);
    endfunction

    function automatic void restore_reset_pattern();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            shadow_regs[i] = RESET_PATTERN;
            sent_regs[i]   = RESET_PATTERN;
        end
        dirty_mask = '0;
    endfunction

    // Applies one accepted command to our copy of the cache and queues the
    // flushed registers that it must produce.
    function automatic void predict_cmd(input cmd_item_t c);
        int        first_grp;
        logic      others;
        logic      have_one;
        res_item_t held;
        res_item_t empty_step;

        case (c.action)
            ACT_SET:
            begin
                if (shadow_regs[c.state_index] != c.new_value)
                begin
                    shadow_regs[c.state_index] = c.new_value;
                    dirty_mask[c.state_index / GROUP_SIZE] = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                first_grp = -1;
                others    = 1'b0;
                have_one  = 1'b0;
                held      = '0;
                for (int g = 0; g < NUM_GROUPS; g++)
                begin
                    if (dirty_mask[g])
                    begin
                        if (first_grp < 0)
                            first_grp = g;
                        else
                            others = 1'b1;
                    end
                end
                if (first_grp >= 0)
                begin
                    dirty_mask[first_grp] = 1'b0;
                    for (int j = first_grp * GROUP_SIZE; j < (first_grp + 1) * GROUP_SIZE; j++)
                    begin
                        if (shadow_regs[j] != sent_regs[j])
                        begin
                            sent_regs[j] = shadow_regs[j];
                            if (have_one)
                                flush_writes.push_back(held);
                            held.write_valid  = 1'b1;
                            held.write_index  = j[IDX_W-1:0];
                            held.write_value  = shadow_regs[j];
                            held.last_of_step = 1'b0;
                            held.more_dirty   = others;
                            have_one = 1'b1;
                        end
                    end
                end
                if (have_one)
                begin
                    held.last_of_step = 1'b1;
                    flush_writes.push_back(held);
                end
                else
                begin
                    // A step that finds nothing to send still reports once.
                    empty_step = '0;
                    empty_step.last_of_step = 1'b1;
                    empty_step.more_dirty   = others;
                    flush_writes.push_back(empty_step);
                end
            end
            ACT_CLEAR:
                restore_reset_pattern();
            default:
                ;
        endcase
    endfunction

    // Idle cycles before the next item, with stretches of back-to-back traffic.
    function automatic int draw_idle(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // Command driver: presents items from the backlog, idling between them.
    always @(posedge clk or negedge rst_n)
    begin
        int           idle;
        bit           can_send;
        pending_cmd_t next_cmd;

        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            gap_left  <= 0;
        end
        else
        begin
            can_send = cmd_backlog.size() > 0;
            if (can_send && cmd_backlog[0].wait_drain)
                can_send = !cmd_valid && open_results == 0;

            if (cmd_valid && !cmd_stall)
            begin
                idle = draw_idle(send_burst);
                if (idle == 0 && can_send)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd <= next_cmd.item;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                    gap_left  <= idle;
                end
            end
            else if (!cmd_valid)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (can_send)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd       <= next_cmd.item;
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: predicts from accepted commands, checks accepted results and
    // stalls the result channel at random.
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        int        idle;

        if (!rst_n)
        begin
            restore_reset_pattern();
            flush_writes.delete();
            res_stall    <= 1'b0;
            stall_left   <= 0;
            open_results <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (flush_writes.size() == 0)
                begin
                    note_failure($sformatf("result item with nothing expected: %p", res));
                end
                else
                begin
                    want = flush_writes.pop_front();
                    if (res.write_valid !== want.write_valid ||
                        res.write_index !== want.write_index ||
                        res.write_value !== want.write_value ||
                        res.last_of_step !== want.last_of_step ||
                        res.more_dirty !== want.more_dirty)
                        note_failure($sformatf({"mismatch: expected valid=%0b index=%0d ",
                            "value=%h last=%0b more=%0b, got valid=%0b index=%0d ",
                            "value=%h last=%0b more=%0b"},
                            want.write_valid, want.write_index, want.write_value,
                            want.last_of_step, want.more_dirty,
                            res.write_valid, res.write_index, res.write_value,
                            res.last_of_step, res.more_dirty));
                end
                idle = draw_idle(recv_burst);
                res_stall  <= idle > 0;
                stall_left <= idle > 0 ? idle - 1 : 0;
            end
            else if (stall_left > 0)
            begin
                res_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                res_stall <= 1'b0;
            end

            if (cmd_valid && !cmd_stall)
                predict_cmd(cmd);

            open_results <= flush_writes.size();
        end
    end

    function automatic void queue_cmd(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                                      input logic [VAL_W-1:0] val, input bit drain);
        pending_cmd_t p;
        p.item.action      = act;
        p.item.state_index = idx;
        p.item.new_value   = val;
        p.wait_drain       = drain;
        cmd_backlog.push_back(p);
    endfunction

    // Stimulus, then the wait for the last results and the verdict.
    initial
    begin
        logic [VAL_W-1:0] value_pool[4];
        int               queued;
        int               roll;
        int               grp;
        int               span;
        int               count;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] idx;

        for (int i = 0; i < 4; i++)
            value_pool[i] = $urandom;

        // Directed part. A flush on a clean cache gives one empty result.
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);
        // Extreme indexes and values, then a set to the value already held.
        queue_cmd(ACT_SET, 8'd0, 32'h0000_0000, 1'b0);
        queue_cmd(ACT_SET, 8'd255, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(ACT_SET, 8'd7, RESET_PATTERN, 1'b0);
        // Two dirty groups: the first step reports more dirty, the second not.
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);
        // A register changed and changed back leaves a dirty group with no change.
        queue_cmd(ACT_SET, 8'd8, 32'h1234_5678, 1'b0);
        queue_cmd(ACT_SET, 8'd8, RESET_PATTERN, 1'b0);
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);
        // A whole group changed gives the longest flush step.
        for (int k = 0; k < GROUP_SIZE; k++)
            queue_cmd(ACT_SET, 8'(16 + k), 32'h5555_5555 ^ (32'h1 << (4 * k)), 1'b0);
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);
        // The unused action is ignored; the sender waits for the flush to drain.
        queue_cmd(2'd3, 8'hA5, 32'hDEAD_BEEF, 1'b1);
        // Clear drops pending changes.
        queue_cmd(ACT_SET, 8'd100, 32'hAAAA_AAAA, 1'b0);
        queue_cmd(ACT_CLEAR, 8'h5A, 32'h0F0F_0F0F, 1'b0);
        queue_cmd(ACT_FLUSH, 8'd0, 32'd0, 1'b0);

        // Random part: bursts of sets around one to three neighbouring groups followed by flush
        // steps, with clears and unused actions mixed in.
        queued = 0;
        while (queued < 95)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                queue_cmd(ACT_CLEAR, 8'($urandom), $urandom, 1'b0);
                queued++;
            end
            else if (roll < 7)
            begin
                queue_cmd(2'd3, 8'($urandom), $urandom, 1'b0);
            end
            else
            begin
                grp   = $urandom_range(0, NUM_GROUPS - 1);
                span  = $urandom_range(1, 3);
                count = $urandom_range(1, 8);
                for (int k = 0; k < count; k++)
                begin
                    idx = 8'((((grp + $urandom_range(0, span - 1)) % NUM_GROUPS) * GROUP_SIZE)
                             + $urandom_range(0, GROUP_SIZE - 1));
                    roll = $urandom_range(0, 9);
                    if (roll < 4)
                        val = $urandom;
                    else if (roll < 6)
                        val = RESET_PATTERN;
                    else
                        val = value_pool[$urandom_range(0, 3)];
                    queue_cmd(ACT_SET, idx, val, 1'b0);
                    queued++;
                end
                count = $urandom_range(1, span + 1);
                for (int k = 0; k < count; k++)
                begin
                    queue_cmd(ACT_FLUSH, 8'($urandom), $urandom, $urandom_range(0, 9) == 0);
                    queued++;
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to be sent and every result to arrive.
        do
            @(negedge clk);
        while (cmd_backlog.size() > 0 || cmd_valid || flush_writes.size() > 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && flush_writes.size() == 0)
            $display("tb_shadow_state_cache_lazy_flush: clean");
        else
            $display("tb_shadow_state_cache_lazy_flush: errors");
        $finish;
    end

endmodule

### shadow_state_cache_lazy_flush.f
sv/ssc_pkg.sv
sv/ssc_ram.sv
sv/ssc_ctrl.sv
sv/ssc_dpath.sv
sv/shadow_state_cache_lazy_flush.sv
sv/ssc_checker.sv
tb/tb_shadow_state_cache_lazy_flush.sv
